// ===== src/ptq_pkg.sv =====
package ptq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  typedef logic [1:0]  req_t;
  typedef logic [2:0]  status_t;

  localparam req_t REQ_ADD   = 2'd0;
  localparam req_t REQ_EXEC  = 2'd1;
  localparam req_t REQ_FIND  = 2'd2;

  localparam status_t ST_ADDED     = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_EXECUTED  = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;
  localparam status_t ST_FOUND     = 3'd5;
  localparam status_t ST_NOT_FOUND = 3'd6;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] exec_time;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    new_entry;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_DRAIN
  } state_t;

endpackage

// ===== src/ptq_cell.sv =====
module ptq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ptq_pkg::cell_ctrl_t ctrl,
  input  logic               prev_ge,
  input  logic               prev_valid,
  input  ptq_pkg::entry_t    prev_entry,
  input  logic               next_valid,
  input  ptq_pkg::entry_t    next_entry,
  output logic               valid,
  output ptq_pkg::entry_t    entry,
  output logic               ge,
  output logic               match
);
  import ptq_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;

  assign ge    = valid_r && (entry_r.prio >= ctrl.new_entry.prio);
  assign match = valid_r && (entry_r.id == ctrl.new_entry.id);

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (!ge) begin
          if (prev_ge) begin
            valid_nxt = 1'b1;
            entry_nxt = ctrl.new_entry;
          end else begin
            valid_nxt = prev_valid;
            entry_nxt = prev_entry;
          end
        end
      end
      CMD_POP: begin
        valid_nxt = next_valid;
        entry_nxt = next_entry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;

endmodule

// ===== src/priority_task_queue_top.sv =====
// Channel  | Ports                                            | Handshake
// ---------+--------------------------------------------------+---------------------------
// request  | in_req_type in_task_id in_prio in_exec_time      | start && !busy
// result   | out_status out_last out_id out_prio out_time     | out_valid, one cycle, no stall
//
// Add and find: busy for one cycle after the request; the result word is registered from state S_OP.
// Execute on n entries: n result words on consecutive cycles, the first registered from
// state S_OP; the row of cells pops one entry per cycle. Empty table: one word.
// Every insert and pop is one step of the cell row; a lookup only compares the ids in all cells.
// Reset clears all cell valid bits, the sequencer and the result strobe.
// The receiver cannot stall; a new request may be taken in the cycle a last word shows.
module priority_task_queue_top #(
  parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_task_id,
  input  logic [7:0]  in_prio,
  input  logic [15:0] in_exec_time,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_last,
  output logic [15:0] out_id,
  output logic [7:0]  out_prio,
  output logic [15:0] out_time
);
  import ptq_pkg::*;

  state_t     state_r, state_nxt;
  req_t       req_r;
  entry_t     req_entry_r;
  cell_ctrl_t ctrl;

  logic   [QUEUE_DEPTH-1:0] cell_valid;
  logic   [QUEUE_DEPTH-1:0] cell_ge;
  logic   [QUEUE_DEPTH-1:0] cell_match;
  entry_t                   cell_entry [QUEUE_DEPTH];

  logic    dup, full;
  entry_t  found_entry;

  logic    res_valid_r, res_valid_nxt;
  status_t res_status_r, res_status_nxt;
  logic    res_last_r, res_last_nxt;
  entry_t  res_entry_r, res_entry_nxt;

  wire accept = start && (state_r == S_IDLE);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic   p_ge, p_valid, n_valid;
      entry_t p_entry, n_entry;
      if (g == 0) begin : g_head
        assign p_ge    = 1'b1;
        assign p_valid = 1'b0;
        assign p_entry = '0;
      end else begin : g_mid
        assign p_ge    = cell_ge[g-1];
        assign p_valid = cell_valid[g-1];
        assign p_entry = cell_entry[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_entry = '0;
      end else begin : g_body
        assign n_valid = cell_valid[g+1];
        assign n_entry = cell_entry[g+1];
      end
      ptq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .prev_ge    (p_ge),
        .prev_valid (p_valid),
        .prev_entry (p_entry),
        .next_valid (n_valid),
        .next_entry (n_entry),
        .valid      (cell_valid[g]),
        .entry      (cell_entry[g]),
        .ge         (cell_ge[g]),
        .match      (cell_match[g])
      );
    end
  endgenerate

  assign dup  = |cell_match;
  assign full = cell_valid[QUEUE_DEPTH-1];

  always_comb begin
    found_entry = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      found_entry = found_entry | (cell_entry[i] & {$bits(entry_t){cell_match[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r       <= in_req_type;
      req_entry_r <= '{id: in_task_id, prio: in_prio, exec_time: in_exec_time};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_OP;
      end
      S_OP: begin
        if (req_r == REQ_EXEC && cell_valid[1]) state_nxt = S_DRAIN;
        else state_nxt = S_IDLE;
      end
      S_DRAIN: begin
        if (!cell_valid[1]) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.cmd       = CMD_HOLD;
    ctrl.new_entry = req_entry_r;
    res_valid_nxt  = 1'b0;
    res_status_nxt = ST_ADDED;
    res_last_nxt   = 1'b1;
    res_entry_nxt  = '0;
    unique case (state_r)
      S_IDLE: ;
      S_OP: begin
        unique case (req_r)
          REQ_ADD: begin
            res_valid_nxt = 1'b1;
            if (dup) begin
              res_status_nxt = ST_DUPLICATE;
            end else if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              res_status_nxt = ST_ADDED;
              ctrl.cmd       = CMD_INSERT;
            end
          end
          REQ_EXEC: begin
            res_valid_nxt = 1'b1;
            if (!cell_valid[0]) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              res_status_nxt = ST_EXECUTED;
              res_last_nxt   = !cell_valid[1];
              res_entry_nxt  = cell_entry[0];
              ctrl.cmd       = CMD_POP;
            end
          end
          REQ_FIND: begin
            res_valid_nxt  = 1'b1;
            res_status_nxt = dup ? ST_FOUND : ST_NOT_FOUND;
            res_entry_nxt  = found_entry;
          end
          default: ;
        endcase
      end
      S_DRAIN: begin
        res_valid_nxt  = 1'b1;
        res_status_nxt = ST_EXECUTED;
        res_last_nxt   = !cell_valid[1];
        res_entry_nxt  = cell_entry[0];
        ctrl.cmd       = CMD_POP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    res_entry_r  <= res_entry_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = res_valid_r;
  assign out_status = res_status_r;
  assign out_last   = res_last_r;
  assign out_id     = res_entry_r.id;
  assign out_prio   = res_entry_r.prio;
  assign out_time   = res_entry_r.exec_time;

endmodule

// ===== src/ptq_checker.sv =====
module ptq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic       out_last
);
  import ptq_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_drain_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("drain stopped before its last word");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result word right after a last word");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_EXECUTED) |-> out_last)
    else $error("non-drain result word without last");

endmodule

bind priority_task_queue_top ptq_checker u_ptq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_last   (out_last)
);

// ===== tb/tb_top.sv =====
module tb_top;
  import ptq_pkg::*;

  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    status_t     status;
    logic        last;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] etime;
  } qres_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [15:0] in_task_id;
  logic [7:0]  in_prio;
  logic [15:0] in_exec_time;
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_last;
  logic [15:0] out_id;
  logic [7:0]  out_prio;
  logic [15:0] out_time;

  logic [15:0] tbl_id   [QUEUE_DEPTH];
  logic [7:0]  tbl_prio [QUEUE_DEPTH];
  logic [15:0] tbl_time [QUEUE_DEPTH];
  int          tbl_count;

  qres_t       due_results[$];
  int          mismatch_count;
  int          stall_cycles;
  int          sender_idle_pct;

  priority_task_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_task_id  (in_task_id),
    .in_prio     (in_prio),
    .in_exec_time(in_exec_time),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_last    (out_last),
    .out_id      (out_id),
    .out_prio    (out_prio),
    .out_time    (out_time)
  );

  initial clk = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_result(status_t st, logic lst, logic [15:0] id, logic [7:0] pr,
                              logic [15:0] tm);
    qres_t r;
    r.status = st;
    r.last   = lst;
    r.id     = id;
    r.prio   = pr;
    r.etime  = tm;
    due_results.push_back(r);
  endtask

  task automatic predict_queue_results(req_t rq, logic [15:0] id, logic [7:0] pr,
                                       logic [15:0] tm);
    int hit;
    int pos;
    hit = -1;
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) hit = i;
    case (rq)
      REQ_ADD: begin
        if (hit >= 0) begin
          queue_result(ST_DUPLICATE, 1'b1, '0, '0, '0);
        end else if (tbl_count >= QUEUE_DEPTH) begin
          queue_result(ST_FULL, 1'b1, '0, '0, '0);
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_prio[pos] >= pr) pos++;
          for (int j = tbl_count; j > pos; j--) begin
            tbl_id[j]   = tbl_id[j-1];
            tbl_prio[j] = tbl_prio[j-1];
            tbl_time[j] = tbl_time[j-1];
          end
          tbl_id[pos]   = id;
          tbl_prio[pos] = pr;
          tbl_time[pos] = tm;
          tbl_count++;
          queue_result(ST_ADDED, 1'b1, '0, '0, '0);
        end
      end
      REQ_EXEC: begin
        if (tbl_count == 0) begin
          queue_result(ST_EMPTY, 1'b1, '0, '0, '0);
        end else begin
          for (int i = 0; i < tbl_count; i++)
            queue_result(ST_EXECUTED, (i == tbl_count - 1), tbl_id[i], tbl_prio[i],
                         tbl_time[i]);
          tbl_count = 0;
        end
      end
      REQ_FIND: begin
        if (hit >= 0)
          queue_result(ST_FOUND, 1'b1, tbl_id[hit], tbl_prio[hit], tbl_time[hit]);
        else
          queue_result(ST_NOT_FOUND, 1'b1, '0, '0, '0);
      end
      default: ;
    endcase
  endtask

  task automatic issue_request(req_t rq, logic [15:0] id, logic [7:0] pr, logic [15:0] tm);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_req_type  <= rq;
    in_task_id   <= id;
    in_prio      <= pr;
    in_exec_time <= tm;
    do @(posedge clk); while (busy);
    predict_queue_results(rq, id, pr, tm);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  function automatic logic [15:0] pick_stored_id();
    if (tbl_count == 0) return 16'($urandom_range(65535));
    return tbl_id[$urandom_range(tbl_count - 1)];
  endfunction

  task automatic test_empty_table();
    issue_request(REQ_EXEC, 16'h0000, 8'h00, 16'h0000);
    issue_request(REQ_FIND, 16'h0000, 8'h00, 16'h0000);
    issue_request(req_t'(2'd3), 16'hFFFF, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_add_and_find();
    issue_request(REQ_ADD, 16'h0000, 8'h00, 16'h0000);
    issue_request(REQ_ADD, 16'hFFFF, 8'hFF, 16'hFFFF);
    issue_request(REQ_ADD, 16'h1234, 8'hFF, 16'h5A5A);
    issue_request(REQ_ADD, 16'h0000, 8'h7F, 16'h0001);
    issue_request(REQ_FIND, 16'hFFFF, 8'h00, 16'h0000);
    issue_request(REQ_FIND, 16'h5555, 8'hAA, 16'hAAAA);
  endtask

  task automatic test_full_table();
    for (int k = 0; k < QUEUE_DEPTH - 3; k++)
      issue_request(REQ_ADD, 16'h0100 + 16'(k), 8'((k % 4) * 8'h40), 16'($urandom_range(65535)));
    issue_request(REQ_ADD, 16'hABCD, 8'h80, 16'h1111);
    issue_request(REQ_ADD, 16'hFFFF, 8'h01, 16'h2222);
    issue_request(REQ_FIND, 16'h0105, 8'h00, 16'h0000);
  endtask

  task automatic test_full_drain();
    issue_request(REQ_EXEC, 16'h0000, 8'h00, 16'h0000);
    wait_all_results();
  endtask

  task automatic test_random(int count, int idle_pct);
    int          drain_pct;
    int          roll;
    logic [15:0] id;
    logic [7:0]  pr;
    req_t        rq;
    sender_idle_pct = idle_pct;
    drain_pct = 10;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: drain_pct = 2;
          1: drain_pct = 10;
          default: drain_pct = 25;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < drain_pct) rq = REQ_EXEC;
      else if (roll < 96) rq = ($urandom_range(99) < 70) ? REQ_ADD : REQ_FIND;
      else rq = req_t'(2'd3);
      if ($urandom_range(99) < 40) id = pick_stored_id();
      else if ($urandom_range(3) == 0) id = 16'($urandom_range(65535));
      else id = 16'($urandom_range(31));
      if ($urandom_range(3) == 0) pr = 8'($urandom_range(3));
      else pr = 8'($urandom_range(255));
      issue_request(rq, id, pr, 16'($urandom_range(65535)));
    end
    wait_all_results();
  endtask

  always @(posedge clk) begin
    qres_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word, status", out_status, 0);
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        if (out_id !== want.id) report_mismatch("id", out_id, want.id);
        if (out_prio !== want.prio) report_mismatch("prio", out_prio, want.prio);
        if (out_time !== want.etime) report_mismatch("time", out_time, want.etime);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = '0;
    in_task_id      = '0;
    in_prio         = '0;
    in_exec_time    = '0;
    tbl_count       = 0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    sender_idle_pct = 24;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_add_and_find();
    test_full_table();
    test_full_drain();
    test_random(127, 24);
    test_random(127, 57);
    test_random(126, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
